@@ rtl/core/oit_pkg.sv @@
// Shared types and constants for the offside-rule indent tracker.
// Holds the channel word structs, token kinds, region codes and stack sizing.
// No dependencies; every other file in rtl/core imports this package.
package oit_pkg;

  // Stack sizing and indent count width.
  localparam int STACK_DEPTH = 16;
  localparam int INDENT_BITS = 8;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  // Line and column counters.
  localparam int POS_W = 16;

  // Tab width register.
  localparam int          TAB_W       = 4;
  localparam logic [3:0]  TAB_W_RESET = 4'd4;

  // Character codes that steer the scanner.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef logic [INDENT_BITS-1:0] indent_t;
  typedef logic [DEPTH_W-1:0]     depth_t;
  typedef logic [POS_W-1:0]       pos_t;

  // Token kinds carried in the result word.
  typedef enum logic [2:0] {
    K_NEWLINE      = 3'd0,
    K_INDENT       = 3'd1,
    K_DEDENT       = 3'd2,
    K_EOF          = 3'd3,
    K_BAD_DEDENT   = 3'd4,
    K_UNTERMINATED = 3'd5,
    K_OVERFLOW     = 3'd6
  } kind_t;

  // Scanner regions.
  typedef enum logic [1:0] {
    RG_NORMAL  = 2'd0,
    RG_COMMENT = 2'd1,
    RG_STRING  = 2'd2,
    RG_LEADING = 2'd3
  } region_t;

  // Input channel word.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_word_t;

  // Result channel word.
  typedef struct packed {
    kind_t kind;
    pos_t  line;
    pos_t  column;
    logic  last;
  } out_word_t;

  // Shift control for the indent stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

endpackage

@@ rtl/core/oit_cell.sv @@
// One cell of the indent stack: holds one indent width.
// Shifts down on a push and up on a pop; depends on oit_pkg.
module oit_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             anchor,
  input  oit_pkg::stk_op_t op,
  input  oit_pkg::indent_t from_up,
  input  oit_pkg::indent_t from_down,
  output oit_pkg::indent_t val
);
  import oit_pkg::*;

  indent_t val_r;

  // The anchor cell holds level zero after reset; other cells start unknown.
  always_ff @(posedge clk) begin
    if (!rst_n && anchor) begin
      val_r <= '0;
    end else if (op.push) begin
      val_r <= from_up;
    end else if (op.pop) begin
      val_r <= from_down;
    end
  end

  assign val = val_r;

endmodule

@@ rtl/core/oit_stack.sv @@
// Indent stack built as a row of oit_cell instances, top of stack in cell 0.
// Depends on oit_pkg and oit_cell.
module oit_stack (
  input  logic             clk,
  input  logic             rst_n,
  input  oit_pkg::stk_op_t op,
  input  oit_pkg::indent_t push_val,
  output oit_pkg::indent_t top,
  output oit_pkg::indent_t second
);
  import oit_pkg::*;

  indent_t val [STACK_DEPTH];
  indent_t up  [STACK_DEPTH];
  indent_t dn  [STACK_DEPTH];

  // Each cell takes its upper neighbor on a push and its lower one on a pop.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign up[i] = push_val;
    end else begin : g_mid_up
      assign up[i] = val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign dn[i] = val[i];
    end else begin : g_mid_dn
      assign dn[i] = val[i+1];
    end

    oit_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .anchor    (i == 0),
      .op        (op),
      .from_up   (up[i]),
      .from_down (dn[i]),
      .val       (val[i])
    );
  end

  assign top    = val[0];
  assign second = val[1];

endmodule

@@ rtl/core/offside_rule_indent_tracker_core.sv @@
// Offside-rule indent tracker: turns a byte stream into NEWLINE, INDENT,
// DEDENT and EOF tokens, plus bad-dedent, unterminated and overflow tokens.
// A result word is in the output register the cycle after the accepting edge.
// Throughput: one input word per cycle while each causes at most one result and
// the output is free; a word with more results holds the input, as the sequencer
// emits one word and shifts the stack one level per unstalled cycle. Sync reset
// clears control state, stack to level zero, tab width to 4; no clearing pass.
module offside_rule_indent_tracker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  oit_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output oit_pkg::out_word_t out_word
);
  import oit_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INDENT,
    S_DEDENT,
    S_BAD,
    S_OVF,
    S_UNTERM,
    S_NEWLINE,
    S_END_POP,
    S_EOF
  } state_t;

  state_t          state_r, state_nxt;
  logic [TAB_W-1:0] tab_width_r, tab_width_nxt;
  region_t         region_r, region_nxt;
  indent_t         space_count_r, space_count_nxt;
  depth_t          depth_r, depth_nxt;
  pos_t            line_count_r, line_count_nxt;
  pos_t            column_count_r, column_count_nxt;
  logic            failed_r, failed_nxt;
  logic            end_r, end_nxt;
  logic            nl_r, nl_nxt;
  indent_t         sp_r, sp_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r, out_word_nxt;

  logic            ld_ok;
  logic            acc;
  logic            fire;
  logic            in_nl;
  logic            in_blank;
  state_t          st0;
  state_t          cur;
  state_t          nxt;
  logic            cur_end;
  logic            cur_nl;
  indent_t         cur_sp;
  indent_t         stk_top;
  indent_t         stk_second;
  stk_op_t         stk_op;
  logic [INDENT_BITS:0] sp_sum;

  // What follows once the indent decision is settled.
  function automatic state_t cont_st(input logic is_end, input logic nl, input logic more);
    state_t s;
    if (is_end) begin
      s = more ? S_END_POP : S_EOF;
    end else begin
      s = nl ? S_NEWLINE : S_IDLE;
    end
    return s;
  endfunction

  // Handshake: a word is taken only when the sequencer and output slot are free.
  assign ld_ok    = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !ld_ok;
  assign acc      = in_valid && !in_stall;

  assign in_nl    = (in_word.ch == CH_NL);
  assign in_blank = (in_word.ch == CH_SPACE) || (in_word.ch == CH_TAB);

  // Held item fields while the sequencer runs, live fields in the idle cycle.
  assign cur_end = (state_r == S_IDLE) ? in_word.is_end : end_r;
  assign cur_nl  = (state_r == S_IDLE) ? in_nl : nl_r;
  assign cur_sp  = (state_r == S_IDLE) ? space_count_r : sp_r;

  // Saturating indent count for the next leading blank.
  assign sp_sum = {1'b0, space_count_r} +
                  ((in_word.ch == CH_TAB) ? (INDENT_BITS+1)'(tab_width_r)
                                          : (INDENT_BITS+1)'(1));

  // First sequencer step for an accepted word.
  always_comb begin
    st0 = S_IDLE;
    unique case (region_r)
      RG_LEADING: begin
        if (in_word.is_end || !in_blank) begin
          if (space_count_r > stk_top) begin
            st0 = (depth_r == DEPTH_W'(STACK_DEPTH)) ? S_OVF : S_INDENT;
          end else if (space_count_r < stk_top) begin
            st0 = S_DEDENT;
          end else begin
            st0 = cont_st(in_word.is_end, in_nl, depth_r > DEPTH_W'(1));
          end
        end
      end
      RG_STRING: begin
        st0 = in_word.is_end ? S_UNTERM : S_IDLE;
      end
      default: begin
        if (in_word.is_end) begin
          st0 = cont_st(1'b1, 1'b0, depth_r > DEPTH_W'(1));
        end else begin
          st0 = in_nl ? S_NEWLINE : S_IDLE;
        end
      end
    endcase
  end

  assign cur  = (state_r != S_IDLE) ? state_r :
                ((acc && !failed_r) ? st0 : S_IDLE);
  assign fire = (cur != S_IDLE) && ld_ok;

  // Scanner state, sequencer and result word.
  always_comb begin
    tab_width_nxt    = cfg_wr_en ? cfg_wr_data : tab_width_r;
    region_nxt       = region_r;
    space_count_nxt  = space_count_r;
    depth_nxt        = depth_r;
    line_count_nxt   = line_count_r;
    column_count_nxt = column_count_r;
    failed_nxt       = failed_r;
    end_nxt          = end_r;
    nl_nxt           = nl_r;
    sp_nxt           = sp_r;
    stk_op           = '0;
    nxt              = S_IDLE;
    out_word_nxt     = out_word_r;

    // Region and position updates that the accepted byte causes.
    if (acc && !failed_r) begin
      end_nxt = in_word.is_end;
      nl_nxt  = in_nl;
      sp_nxt  = space_count_r;
      if (in_word.is_end) begin
        if (region_r == RG_LEADING) begin
          region_nxt      = RG_NORMAL;
          space_count_nxt = '0;
        end
      end else begin
        unique case (region_r)
          RG_LEADING: begin
            if (in_blank) begin
              space_count_nxt = sp_sum[INDENT_BITS] ? '1 : sp_sum[INDENT_BITS-1:0];
              if (column_count_r != '1) column_count_nxt = column_count_r + 1'b1;
            end else begin
              region_nxt      = RG_NORMAL;
              space_count_nxt = '0;
              if (!in_nl) begin
                if (in_word.ch == CH_HASH) region_nxt = RG_COMMENT;
                else if (in_word.ch == CH_QUOTE) region_nxt = RG_STRING;
                if (column_count_r != '1) column_count_nxt = column_count_r + 1'b1;
              end
            end
          end
          RG_COMMENT: begin
            if (!in_nl && column_count_r != '1) column_count_nxt = column_count_r + 1'b1;
          end
          RG_STRING: begin
            if (in_word.ch == CH_QUOTE) region_nxt = RG_NORMAL;
            if (column_count_r != '1) column_count_nxt = column_count_r + 1'b1;
          end
          RG_NORMAL: begin
            if (!in_nl) begin
              if (in_word.ch == CH_HASH) region_nxt = RG_COMMENT;
              else if (in_word.ch == CH_QUOTE) region_nxt = RG_STRING;
              if (column_count_r != '1) column_count_nxt = column_count_r + 1'b1;
            end
          end
        endcase
      end
    end

    // One result word per firing step.
    if (fire) begin
      out_word_nxt.line   = line_count_r;
      out_word_nxt.column = column_count_r;
      out_word_nxt.kind   = K_EOF;
      unique case (cur)
        S_INDENT: begin
          out_word_nxt.kind   = K_INDENT;
          out_word_nxt.column = POS_W'(1);
          stk_op.push         = 1'b1;
          depth_nxt           = depth_r + 1'b1;
          nxt                 = cont_st(cur_end, cur_nl, 1'b1);
        end
        S_DEDENT: begin
          out_word_nxt.kind   = K_DEDENT;
          out_word_nxt.column = POS_W'(1);
          stk_op.pop          = 1'b1;
          depth_nxt           = depth_r - 1'b1;
          if (cur_sp < stk_second) begin
            nxt = S_DEDENT;
          end else if (cur_sp > stk_second) begin
            nxt = S_BAD;
          end else begin
            nxt = cont_st(cur_end, cur_nl, depth_r > DEPTH_W'(2));
          end
        end
        S_BAD: begin
          out_word_nxt.kind   = K_BAD_DEDENT;
          out_word_nxt.column = POS_W'(1);
          failed_nxt          = 1'b1;
        end
        S_OVF: begin
          out_word_nxt.kind = K_OVERFLOW;
          failed_nxt        = 1'b1;
        end
        S_UNTERM: begin
          out_word_nxt.kind = K_UNTERMINATED;
          failed_nxt        = 1'b1;
        end
        S_NEWLINE: begin
          out_word_nxt.kind = K_NEWLINE;
          if (line_count_r != '1) line_count_nxt = line_count_r + 1'b1;
          column_count_nxt = POS_W'(1);
          region_nxt       = RG_LEADING;
          space_count_nxt  = '0;
        end
        S_END_POP: begin
          out_word_nxt.kind = K_DEDENT;
          stk_op.pop        = 1'b1;
          depth_nxt         = depth_r - 1'b1;
          nxt               = (depth_r > DEPTH_W'(2)) ? S_END_POP : S_EOF;
        end
        S_EOF: begin
          out_word_nxt.kind = K_EOF;
        end
        S_IDLE: begin
          out_word_nxt.kind = K_EOF;
        end
      endcase
      out_word_nxt.last = (nxt == S_IDLE);
    end

    state_nxt     = fire ? nxt : state_r;
    out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      tab_width_r    <= TAB_W_RESET;
      region_r       <= RG_NORMAL;
      space_count_r  <= '0;
      depth_r        <= DEPTH_W'(1);
      line_count_r   <= POS_W'(1);
      column_count_r <= POS_W'(1);
      failed_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      tab_width_r    <= tab_width_nxt;
      region_r       <= region_nxt;
      space_count_r  <= space_count_nxt;
      depth_r        <= depth_nxt;
      line_count_r   <= line_count_nxt;
      column_count_r <= column_count_nxt;
      failed_r       <= failed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    end_r      <= end_nxt;
    nl_r       <= nl_nxt;
    sp_r       <= sp_nxt;
    out_word_r <= out_word_nxt;
  end

  // Indent stack as a row of shifting cells.
  oit_stack u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (stk_op),
    .push_val (cur_sp),
    .top      (stk_top),
    .second   (stk_second)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  // A push never goes past the last cell.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stk_op.push |-> (depth_r < DEPTH_W'(STACK_DEPTH)))
    else $error("indent stack push while full");

  // A pop never removes level zero.
  a_pop_floor: assert property (@(posedge clk) disable iff (!rst_n)
    stk_op.pop |-> (depth_r > DEPTH_W'(1)))
    else $error("indent stack pop at level zero");

  // After a failure no further word is produced.
  a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> !fire)
    else $error("result word after failure");

  // The word marked last returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_word_nxt.last) |=> (state_r == S_IDLE))
    else $error("sequencer busy after last word");
`endif

endmodule

@@ sim/offside_rule_indent_tracker_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for offside_rule_indent_tracker_core.
// Streams source bytes through the input channel, predicts the token words and
// compares each result word in order. Depends only on oit_pkg and the core.

import oit_pkg::*;

// Token predictor plus the queue of token words still owed by the block.
class token_scoreboard;
  localparam int   INDENT_MAX = (1 << INDENT_BITS) - 1;
  localparam pos_t POS_MAX    = '1;

  logic [3:0]  tab_width;
  region_t     region;
  indent_t     space_count;
  indent_t     levels[STACK_DEPTH];
  int          depth;
  pos_t        line_no;
  pos_t        col_no;
  bit          failed;
  out_word_t   step_tokens[$];
  out_word_t   expected_tokens[$];
  int unsigned n_errors;
  int unsigned n_checked;

  function new();
    tab_width   = TAB_W_RESET;
    region      = RG_NORMAL;
    space_count = '0;
    foreach (levels[i]) levels[i] = '0;
    depth       = 1;
    line_no     = pos_t'(1);
    col_no      = pos_t'(1);
    failed      = 1'b0;
    n_errors    = 0;
    n_checked   = 0;
  endfunction

  function void emit(kind_t k, pos_t ln, pos_t cl);
    out_word_t t;
    t.kind   = k;
    t.line   = ln;
    t.column = cl;
    t.last   = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function void bump_column();
    if (col_no != POS_MAX) col_no++;
  endfunction

  function void line_break();
    emit(K_NEWLINE, line_no, col_no);
    if (line_no != POS_MAX) line_no++;
    col_no      = pos_t'(1);
    region      = RG_LEADING;
    space_count = '0;
  endfunction

  // Compare the leading width with the stack: push a level, pop levels or fail.
  function void decide_indent();
    indent_t sp;
    sp          = space_count;
    region      = RG_NORMAL;
    space_count = '0;
    if (sp > levels[depth-1]) begin
      if (depth >= STACK_DEPTH) begin
        emit(K_OVERFLOW, line_no, col_no);
        failed = 1'b1;
        return;
      end
      levels[depth] = sp;
      depth++;
      emit(K_INDENT, line_no, pos_t'(1));
      return;
    end
    while (depth > 1 && sp < levels[depth-1]) begin
      depth--;
      emit(K_DEDENT, line_no, pos_t'(1));
    end
    if (sp != levels[depth-1]) begin
      emit(K_BAD_DEDENT, line_no, pos_t'(1));
      failed = 1'b1;
    end
  endfunction

  function void plain_byte(logic [7:0] c);
    if (c == CH_NL) begin
      line_break();
      return;
    end
    if (c == CH_HASH) region = RG_COMMENT;
    else if (c == CH_QUOTE) region = RG_STRING;
    bump_column();
  endfunction

  function void end_of_input();
    if (region == RG_STRING) begin
      emit(K_UNTERMINATED, line_no, col_no);
      failed = 1'b1;
      return;
    end
    if (region == RG_LEADING) begin
      decide_indent();
      if (failed) return;
    end
    while (depth > 1) begin
      depth--;
      emit(K_DEDENT, line_no, col_no);
    end
    emit(K_EOF, line_no, col_no);
  endfunction

  // Advance the model by one input word; the tokens land in step_tokens.
  function int predict_tokens(in_word_t w);
    int add;
    int sum;
    out_word_t t;
    step_tokens.delete();
    if (failed) return 0;
    if (w.is_end) begin
      end_of_input();
    end else if (region == RG_LEADING) begin
      if (w.ch == CH_SPACE || w.ch == CH_TAB) begin
        add = (w.ch == CH_TAB) ? int'(tab_width) : 1;
        sum = int'(space_count) + add;
        space_count = (sum > INDENT_MAX) ? indent_t'(INDENT_MAX) : indent_t'(sum);
        bump_column();
      end else begin
        decide_indent();
        if (!failed) plain_byte(w.ch);
      end
    end else if (region == RG_COMMENT) begin
      if (w.ch == CH_NL) line_break();
      else bump_column();
    end else if (region == RG_STRING) begin
      if (w.ch == CH_QUOTE) region = RG_NORMAL;
      bump_column();
    end else begin
      plain_byte(w.ch);
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens[step_tokens.size()-1];
      t.last = 1'b1;
      step_tokens[step_tokens.size()-1] = t;
    end
    return step_tokens.size();
  endfunction

  function void note_input(in_word_t w);
    void'(predict_tokens(w));
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endfunction

  function int pending();
    return expected_tokens.size();
  endfunction

  task report(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  task check_token(out_word_t got);
    out_word_t want;
    n_checked++;
    if (expected_tokens.size() == 0) begin
      report($sformatf("token with none owed: kind=%0d line=%0d col=%0d last=%0b",
                       got.kind, got.line, got.column, got.last));
      return;
    end
    want = expected_tokens[0];
    expected_tokens.delete(0);
    if (got.kind !== want.kind)
      report($sformatf("token %0d kind %0d, want %0d", n_checked, got.kind, want.kind));
    if (got.line !== want.line)
      report($sformatf("token %0d line %0d, want %0d", n_checked, got.line, want.line));
    if (got.column !== want.column)
      report($sformatf("token %0d column %0d, want %0d", n_checked, got.column, want.column));
    if (got.last !== want.last)
      report($sformatf("token %0d last %0b, want %0b", n_checked, got.last, want.last));
  endtask
endclass

module offside_rule_indent_tracker_core_test;

  localparam int LIMIT        = 2_000_000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 50;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_LIMIT  = 20_000;
  localparam int TAIL_CYCLES  = 20;
  localparam int INDENT_TOP   = (1 << INDENT_BITS) - 1;

  typedef enum {FAULT_BAD_DEDENT, FAULT_OVERFLOW, FAULT_OPEN_STRING} fault_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;

  token_scoreboard sb;
  token_scoreboard lookahead;
  int          burst_left;
  int          items_fed;
  bit          no_idle;
  bit          hold_request;
  bit          hold_done;
  int unsigned cycle_count;

  offside_rule_indent_tracker_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watch both channels: a word moves when valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) sb.note_input(in_word);
      if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_token(out_word);
    end
  end

  // Offer one word, with bursts and random gaps; return once it is taken.
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The lookahead copy tracks where the stream stands as words are generated.
  task automatic feed(input in_word_t w);
    void'(lookahead.predict_tokens(w));
    items_fed++;
    send_word(w);
  endtask

  task automatic feed_char(input logic [7:0] c);
    in_word_t w;
    w.ch     = c;
    w.is_end = 1'b0;
    feed(w);
  endtask

  task automatic feed_end();
    in_word_t w;
    w.ch     = 8'($urandom_range(0, 255));
    w.is_end = 1'b1;
    feed(w);
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_char(s[i]);
  endtask

  // Close out the stream and land at the start of a line with one level open.
  task automatic settle();
    if (lookahead.region == RG_STRING) feed_char(CH_QUOTE);
    feed_end();
    feed_char(CH_NL);
  endtask

  // Stop offering words and wait for every owed token, then a short tail.
  task automatic drain_tokens();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_tab_width(input logic [3:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.tab_width        = v;
    lookahead.tab_width = v;
  endtask

  // Body byte, biased toward the characters that steer the scanner.
  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 11))
      0:       return CH_QUOTE;
      1:       return CH_HASH;
      2:       return CH_NL;
      3:       return CH_SPACE;
      4:       return CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One source line whose indent the stack accepts, with random content.
  task automatic random_line();
    int         target;
    int         rem;
    int         tw;
    int         left;
    indent_t    top;
    logic [7:0] c;
    tw  = int'(lookahead.tab_width);
    top = lookahead.levels[lookahead.depth-1];
    if (lookahead.depth < STACK_DEPTH && int'(top) < INDENT_TOP &&
        $urandom_range(0, 9) < 4) begin
      target = int'(top) + $urandom_range(1, 6);
      if (target > INDENT_TOP) target = INDENT_TOP;
    end else begin
      target = int'(lookahead.levels[$urandom_range(0, lookahead.depth - 1)]);
    end
    // Leading whitespace: a mix of tabs and spaces that adds up to the target.
    rem = target;
    while (rem > 0) begin
      if (tw > 0 && tw <= rem && $urandom_range(0, 2) == 0) begin
        feed_char(CH_TAB);
        rem -= tw;
      end else if (tw == 0 && $urandom_range(0, 4) == 0) begin
        feed_char(CH_TAB);
      end else begin
        feed_char(CH_SPACE);
        rem--;
      end
    end
    if ($urandom_range(0, 19) == 0) feed_end();
    // First byte that is neither space nor tab makes the indent decision.
    if (lookahead.region == RG_LEADING) begin
      case ($urandom_range(0, 5))
        0:       c = CH_NL;
        1:       c = CH_HASH;
        2:       c = CH_QUOTE;
        default: begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_SPACE || c == CH_TAB) c = c ^ 8'h40;
        end
      endcase
      feed_char(c);
    end
    // Body until a real line break; strings are always closed again.
    left = $urandom_range(0, 12);
    while (lookahead.region != RG_LEADING) begin
      if (lookahead.region == RG_STRING) begin
        feed_char((left > 0) ? content_byte() : CH_QUOTE);
      end else if (left > 0 && $urandom_range(0, 39) == 0) begin
        feed_end();
      end else begin
        feed_char((left > 0) ? content_byte() : CH_NL);
      end
      if (left > 0) left--;
    end
  endtask

  // Receiver: stall patterns of its own, plus one long hold-off on request.
  initial begin
    int mode;
    int run_len;
    out_stall <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(1, 40);
      for (int k = 0; k < run_len; k++) begin
        @(posedge clk);
        if (hold_request && !hold_done) begin
          hold_done = 1'b1;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
        end else if (no_idle) begin
          out_stall <= 1'b0;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [3:0] phase_tab[PHASES];
    logic [3:0] tw;
    fault_t     fault;
    sb           = new();
    lookahead    = new();
    burst_left   = 0;
    items_fed    = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    phase_tab    = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4};
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_word     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: comment, tab in the indent, newline inside a string, blank
    // line dedent, comment-only line indent, end in leading whitespace, a
    // second end, and the byte extremes.
    feed_text("a#x\n  \tb\"q\nr\"\n\n #c\n  ");
    feed_end();
    feed_end();
    feed_char(8'h00);
    feed_char(8'hFF);
    settle();
    drain_tokens();

    // Random lines under several tab widths, the extremes among them.
    for (int p = 0; p < PHASES; p++) begin
      tw = (p == PHASES - 1) ? 4'($urandom_range(0, 15)) : phase_tab[p];
      write_tab_width(tw);
      if (p == 1) hold_request = 1'b1;
      begin
        int start;
        start = items_fed;
        while (items_fed - start < PHASE_ITEMS) random_line();
      end
      settle();
      drain_tokens();
    end

    // Saturation of the space count, reached quickly with wide tabs.
    no_idle = 1'b1;
    write_tab_width(4'd15);
    repeat (18) feed_char(CH_TAB);
    repeat (3) feed_char(CH_SPACE);
    feed_char(CH_TAB);
    feed_text("x\ny\n");
    settle();
    drain_tokens();
    no_idle = 1'b0;

    // One sticky fault per run; afterwards the block owes nothing more.
    fault = fault_t'($urandom_range(0, 2));
    case (fault)
      FAULT_BAD_DEDENT: feed_text("  x\n x\n");
      FAULT_OVERFLOW: begin
        for (int lvl = 1; lvl <= STACK_DEPTH; lvl++) begin
          repeat (lvl) feed_char(CH_SPACE);
          feed_text("x\n");
        end
      end
      default: begin
        feed_text("a\"b\n");
        feed_end();
      end
    endcase
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(0, 3) == 0) feed_end();
      else feed_char(8'($urandom_range(0, 255)));
    end
    drain_tokens();

    if (sb.pending() != 0) sb.report($sformatf("%0d tokens never arrived", sb.pending()));
    if (sb.n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/oit_pkg.sv
rtl/core/oit_cell.sv
rtl/core/oit_stack.sv
rtl/core/offside_rule_indent_tracker_core.sv
sim/offside_rule_indent_tracker_core_test.sv
